>>> hw/rtl/kss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_pkg
// Shared types and codes of the k-th smallest selector: sequencer states,
// result status codes, register indexes and the start request.
// ----------------------------------------------------------------------------
package kss_pkg;

  localparam int RANK_W   = 6;
  localparam int STATUS_W = 2;
  localparam int CFG_AW   = 1;
  localparam int CFG_DW   = 6;

  typedef enum logic [CFG_AW-1:0] {
    REG_MEDIAN_MODE = 1'b0,
    REG_RANK        = 1'b1
  } reg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_RANGE    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OUTER,
    S_PIVOT,
    S_SCAN_I,
    S_SCAN_J,
    S_SWAP,
    S_NARROW,
    S_RESULT,
    S_DONE
  } sel_state_t;

  typedef struct packed {
    logic    valid;
    status_t status;
  } start_req_t;

endpackage

>>> hw/rtl/kss_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_store
// Element store: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module kss_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

>>> hw/rtl/kss_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_core
// Selection sequencer: holds the element store and runs the in-place
// two-pointer partition with one shared signed comparator.
// ----------------------------------------------------------------------------
module kss_core #(
  parameter int MAX_COUNT   = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  kss_pkg::start_req_t          start_req,
  input  logic [$clog2(MAX_COUNT)-1:0] hi_in,
  input  logic [$clog2(MAX_COUNT)-1:0] k_in,
  input  logic                         load_we,
  input  logic [$clog2(MAX_COUNT)-1:0] load_addr,
  input  logic [VALUE_WIDTH-1:0]       load_data,
  output logic                         idle,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [VALUE_WIDTH-1:0]       res_value,
  output kss_pkg::status_t             res_status
);
  import kss_pkg::*;

  localparam int IW = $clog2(MAX_COUNT);
  localparam int PW = IW + 2;

  sel_state_t state_r, state_nxt;

  logic signed [PW-1:0] lo_r, lo_nxt;
  logic signed [PW-1:0] hi_r, hi_nxt;
  logic signed [PW-1:0] i_r, i_nxt;
  logic signed [PW-1:0] j_r, j_nxt;
  logic signed [PW-1:0] i_inc, j_dec, kk_s;
  logic [IW-1:0]        kk_r, kk_nxt;

  logic [VALUE_WIDTH-1:0] pivot_r, pivot_nxt;
  logic [VALUE_WIDTH-1:0] val_i_r, val_i_nxt;
  logic [VALUE_WIDTH-1:0] res_value_r, res_value_nxt;
  status_t                res_status_r, res_status_nxt;

  logic                   mem_we;
  logic [IW-1:0]          mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [IW-1:0]          addr_a, addr_b;
  logic [VALUE_WIDTH-1:0] rd_a, rd_b;

  logic [VALUE_WIDTH-1:0] cmp_a, cmp_b;
  logic                   lt;

  kss_store #(
    .DEPTH (MAX_COUNT),
    .WIDTH (VALUE_WIDTH)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (addr_a),
    .raddr_b (addr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign lt    = $signed(cmp_a) < $signed(cmp_b);
  assign i_inc = i_r + PW'(1);
  assign j_dec = j_r - PW'(1);
  assign kk_s  = $signed({2'b00, kk_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    kk_r         <= kk_nxt;
    pivot_r      <= pivot_nxt;
    val_i_r      <= val_i_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    kk_nxt         = kk_r;
    pivot_nxt      = pivot_r;
    val_i_nxt      = val_i_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    mem_we         = load_we;
    mem_waddr      = load_addr;
    mem_wdata      = load_data;
    addr_a         = kk_r;
    addr_b         = j_r[IW-1:0];
    cmp_a          = rd_a;
    cmp_b          = pivot_r;
    res_valid      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start_req.valid) begin
          res_status_nxt = start_req.status;
          if (start_req.status != ST_OK) begin
            res_value_nxt = '0;
            state_nxt     = S_DONE;
          end else begin
            lo_nxt    = '0;
            hi_nxt    = $signed({2'b00, hi_in});
            kk_nxt    = k_in;
            state_nxt = S_OUTER;
          end
        end
      end
      S_OUTER: begin
        addr_a = kk_r;
        if (lo_r < hi_r) begin
          state_nxt = S_PIVOT;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_PIVOT: begin
        pivot_nxt = rd_a;
        i_nxt     = lo_r;
        j_nxt     = hi_r;
        addr_a    = lo_r[IW-1:0];
        state_nxt = S_SCAN_I;
      end
      S_SCAN_I: begin
        cmp_a = rd_a;
        cmp_b = pivot_r;
        if ((i_r < hi_r) && lt) begin
          i_nxt  = i_inc;
          addr_a = i_inc[IW-1:0];
        end else begin
          val_i_nxt = rd_a;
          addr_b    = j_r[IW-1:0];
          state_nxt = S_SCAN_J;
        end
      end
      S_SCAN_J: begin
        cmp_a = pivot_r;
        cmp_b = rd_b;
        if ((j_r > lo_r) && lt) begin
          j_nxt  = j_dec;
          addr_b = j_dec[IW-1:0];
        end else if (i_r <= j_r) begin
          mem_we    = 1'b1;
          mem_waddr = i_r[IW-1:0];
          mem_wdata = rd_b;
          state_nxt = S_SWAP;
        end else begin
          state_nxt = S_NARROW;
        end
      end
      S_SWAP: begin
        mem_we    = 1'b1;
        mem_waddr = j_r[IW-1:0];
        mem_wdata = val_i_r;
        i_nxt     = i_inc;
        j_nxt     = j_dec;
        if (i_inc <= j_dec) begin
          addr_a    = i_inc[IW-1:0];
          state_nxt = S_SCAN_I;
        end else begin
          state_nxt = S_NARROW;
        end
      end
      S_NARROW: begin
        if (j_r < kk_s) begin
          lo_nxt = i_r;
        end
        if (kk_s < i_r) begin
          hi_nxt = j_r;
        end
        state_nxt = S_OUTER;
      end
      S_RESULT: begin
        res_value_nxt = rd_a;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign idle       = (state_r == S_IDLE);
  assign res_value  = res_value_r;
  assign res_status = res_status_r;

endmodule

>>> hw/rtl/kth_smallest_selector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_smallest_selector_unit
// Collects a set of signed values and returns the element of a chosen rank.
// ----------------------------------------------------------------------------
// Values are loaded at one request per cycle while the core is idle into a
// MAX_COUNT-entry store; the request marked by tlast closes the set and
// starts an in-place partition selection run by one sequencer with a
// single shared comparator and a two-read, one-write store. Each partition
// pass reads its pivot, moves the scan pointers one step at a time, swaps
// out-of-place pairs in the store and narrows the range toward the rank;
// the result is read once the range closes. Input is not accepted while a
// selection runs; an error status (overflow, rank out of range) skips the
// partition and goes from the core's done state into the output register.
// The store needs no clearing after reset. A finished result waits in the
// output register while loading of the next set proceeds.
// ----------------------------------------------------------------------------
module kth_smallest_selector_unit #(
  parameter int MAX_COUNT   = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // value
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    in_tdata,
  input  logic                                in_tlast,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // selected_value
  output logic [((VALUE_WIDTH+7)/8)*8-1:0]    out_tdata,
  // status
  output logic [kss_pkg::STATUS_W-1:0]        out_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [kss_pkg::CFG_AW-1:0]          cfg_addr,
  input  logic [kss_pkg::CFG_DW-1:0]          cfg_wdata
);
  import kss_pkg::*;

  localparam int IW   = $clog2(MAX_COUNT);
  localparam int CW   = $clog2(MAX_COUNT + 1);
  localparam int KW   = (CW > RANK_W) ? CW : RANK_W;
  localparam int DW   = ((VALUE_WIDTH + 7) / 8) * 8;

  logic              median_mode_r;
  logic [RANK_W-1:0] rank_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic              overflow_r, overflow_nxt;

  logic              accept;
  logic              room;
  logic [CW-1:0]     cnt_new;
  logic              ovf_new;
  logic [KW-1:0]     k_full;
  logic [KW-1:0]     cnt_ext;
  status_t           status_new;
  start_req_t        start_req;
  logic [IW-1:0]     hi_in;

  logic                   core_idle;
  logic                   res_valid;
  logic                   res_ready;
  logic [VALUE_WIDTH-1:0] res_value;
  status_t                res_status;

  logic                   out_valid_r;
  logic [DW-1:0]          out_data_r;
  status_t                out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      median_mode_r <= 1'b1;
      rank_r        <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MEDIAN_MODE: median_mode_r <= cfg_wdata[0];
        REG_RANK:        rank_r        <= cfg_wdata[RANK_W-1:0];
        default:         ;
      endcase
    end
  end

  assign in_tready = core_idle;
  assign accept    = in_tvalid && in_tready;
  assign room      = (count_r < CW'(MAX_COUNT));
  assign cnt_new   = room ? (count_r + CW'(1)) : count_r;
  assign ovf_new   = overflow_r || !room;
  assign cnt_ext   = KW'(cnt_new);
  assign k_full    = median_mode_r ? KW'(cnt_new >> 1) : KW'(rank_r);
  assign hi_in     = IW'(cnt_new - CW'(1));

  always_comb begin
    if (ovf_new) begin
      status_new = ST_OVERFLOW;
    end else if (cnt_new == '0) begin
      status_new = ST_EMPTY;
    end else if (k_full >= cnt_ext) begin
      status_new = ST_RANGE;
    end else begin
      status_new = ST_OK;
    end
  end

  assign start_req.valid  = accept && in_tlast;
  assign start_req.status = status_new;

  always_comb begin
    count_nxt    = count_r;
    overflow_nxt = overflow_r;
    if (accept) begin
      if (in_tlast) begin
        count_nxt    = '0;
        overflow_nxt = 1'b0;
      end else begin
        count_nxt    = cnt_new;
        overflow_nxt = ovf_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      overflow_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      overflow_r <= overflow_nxt;
    end
  end

  kss_core #(
    .MAX_COUNT   (MAX_COUNT),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_req  (start_req),
    .hi_in      (hi_in),
    .k_in       (k_full[IW-1:0]),
    .load_we    (accept && room),
    .load_addr  (count_r[IW-1:0]),
    .load_data  (in_tdata[VALUE_WIDTH-1:0]),
    .idle       (core_idle),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_value  (res_value),
    .res_status (res_status)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r   <= DW'(res_value);
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule
